/* rtl/ookd_pkg.sv */
// shared types, constants and field decode for the ook remote frame decoder
package ookd_pkg;

  localparam int WIDTH_BITS     = 14;
  localparam int WORD_BITS      = 32;
  localparam int SENDER_BITS    = 26;
  localparam int FRAME_BITS_DEF = 32;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [WIDTH_BITS-1:0] SYNC_MIN_RST  = 14'd2250;
  localparam logic [WIDTH_BITS-1:0] SYNC_MAX_RST  = 14'd2750;
  localparam logic [WIDTH_BITS-1:0] LONG_MIN_RST  = 14'd1000;
  localparam logic [WIDTH_BITS-1:0] LONG_MAX_RST  = 14'd1500;
  localparam logic [WIDTH_BITS-1:0] SHORT_MIN_RST = 14'd200;
  localparam logic [WIDTH_BITS-1:0] SHORT_MAX_RST = 14'd300;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  typedef enum logic [1:0] {
    CL_NONE,
    CL_LONG,
    CL_SHORT
  } pclass_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SYNC_MIN,
    CFG_SYNC_MAX,
    CFG_LONG_MIN,
    CFG_LONG_MAX,
    CFG_SHORT_MIN,
    CFG_SHORT_MAX
  } cfg_idx_t;

  localparam logic [1:0] PK_OTHER = 2'd0;
  localparam logic [1:0] PK_ONES  = 2'd1;
  localparam logic [1:0] PK_ZEROS = 2'd2;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] sync_min;
    logic [WIDTH_BITS-1:0] sync_max;
    logic [WIDTH_BITS-1:0] long_min;
    logic [WIDTH_BITS-1:0] long_max;
    logic [WIDTH_BITS-1:0] short_min;
    logic [WIDTH_BITS-1:0] short_max;
  } cfg_t;

  typedef struct packed {
    logic                   frame_ok;
    logic [WORD_BITS-1:0]   raw_word;
    logic [SENDER_BITS-1:0] sender_number;
    logic                   switch_on;
    logic                   group_flag;
    logic [1:0]             protocol_kind;
    logic [1:0]             button_index;
  } result_t;

  // all-zero word gives the error result
  function automatic result_t decode_word(input logic [WORD_BITS-1:0] word);
    result_t res;
    res = '0;
    if (word != '0) begin
      res.frame_ok      = 1'b1;
      res.raw_word      = word;
      res.sender_number = word[WORD_BITS-1:6];
      res.switch_on     = ~word[4];
      res.group_flag    = ~word[5];
      case (word[3:2])
        2'b11:   res.protocol_kind = PK_ONES;
        2'b00:   res.protocol_kind = PK_ZEROS;
        default: res.protocol_kind = PK_OTHER;
      endcase
      res.button_index  = word[1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/ookd_step.sv */
// pulse classification and frame state transition for one pulse
module ookd_step import ookd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int CNT_BITS   = $clog2(FRAME_BITS + 1)
) (
  input  logic [WIDTH_BITS-1:0] pulse_width,
  input  cfg_t                  cfg,
  input  phase_t                phase,
  input  pclass_t               first_class,
  input  logic [CNT_BITS-1:0]   bit_count,
  input  logic [WORD_BITS-1:0]  shift_word,
  output phase_t                phase_nxt,
  output pclass_t               first_class_nxt,
  output logic [CNT_BITS-1:0]   bit_count_nxt,
  output logic [WORD_BITS-1:0]  shift_word_nxt,
  output logic                  emit,
  output result_t               result
);

  localparam int IDX_BITS = $clog2(WORD_BITS);

  logic                 in_sync;
  logic                 in_long;
  logic                 in_short;
  logic                 pair_ok;
  logic                 frame_done;
  logic [CNT_BITS-1:0]  count_inc;
  logic [IDX_BITS-1:0]  bit_idx;
  logic [WORD_BITS-1:0] word_set;

  assign in_sync  = (pulse_width > cfg.sync_min)  && (pulse_width < cfg.sync_max);
  assign in_long  = (pulse_width > cfg.long_min)  && (pulse_width < cfg.long_max);
  assign in_short = (pulse_width > cfg.short_min) && (pulse_width < cfg.short_max);

  assign pair_ok = ((first_class == CL_LONG) && in_short) ||
                   ((first_class == CL_SHORT) && in_long);

  // first bit lands in the msb
  assign bit_idx    = IDX_BITS'(WORD_BITS - 1 - int'(bit_count));
  assign word_set   = (first_class == CL_SHORT) ?
                      (shift_word | (WORD_BITS'(1) << bit_idx)) : shift_word;
  assign count_inc  = bit_count + CNT_BITS'(1);
  assign frame_done = (count_inc >= CNT_BITS'(FRAME_BITS));

  // next state
  always_comb begin
    phase_nxt       = PH_IDLE;
    first_class_nxt = CL_NONE;
    bit_count_nxt   = '0;
    shift_word_nxt  = '0;
    case (phase)
      PH_FIRST: begin
        if (in_long) begin
          phase_nxt       = PH_SECOND;
          first_class_nxt = CL_LONG;
          bit_count_nxt   = bit_count;
          shift_word_nxt  = shift_word;
        end else if (in_short) begin
          phase_nxt       = PH_SECOND;
          first_class_nxt = CL_SHORT;
          bit_count_nxt   = bit_count;
          shift_word_nxt  = shift_word;
        end
      end
      PH_SECOND: begin
        if (pair_ok && !frame_done) begin
          phase_nxt      = PH_FIRST;
          bit_count_nxt  = count_inc;
          shift_word_nxt = word_set;
        end
      end
      default: begin
        if (in_sync) begin
          phase_nxt = PH_FIRST;
        end
      end
    endcase
  end

  // result
  always_comb begin
    emit   = 1'b0;
    result = '0;
    case (phase)
      PH_FIRST: begin
        emit = !(in_long || in_short);
      end
      PH_SECOND: begin
        if (!pair_ok) begin
          emit = 1'b1;
        end else if (frame_done) begin
          emit   = 1'b1;
          result = decode_word(word_set);
        end
      end
      default: begin
        emit = !in_sync;
      end
    endcase
  end

endmodule

/* rtl/ook_remote_frame_decoder_core.sv */
// top level of the ook remote frame decoder: config registers, pulse stage, result stage
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_pulse_width
//  out_     output     out_valid/out_stall  frame_ok, raw_word, sender_number, switch_on,
//                                           group_flag, protocol_kind, button_index
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pulse per cycle sustained while the output is not stalled; from accept to result a
// pulse goes through the pulse register, then the result register; the frame state
// updates as the pulse leaves the pulse register
// synchronous active-low reset: windows to their defaults, frame state idle, stages empty
// a result stalled at the output still lets one more pulse into the pulse register;
// in_stall rises only when both registers are full and the output is stalled
// cfg_ready is always high; a write to an index past the list is dropped
module ook_remote_frame_decoder_core import ookd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WIDTH_BITS-1:0]   in_pulse_width,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_frame_ok,
  output logic [WORD_BITS-1:0]    out_raw_word,
  output logic [SENDER_BITS-1:0]  out_sender_number,
  output logic                    out_switch_on,
  output logic                    out_group_flag,
  output logic [1:0]              out_protocol_kind,
  output logic [1:0]              out_button_index,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WIDTH_BITS-1:0]   cfg_data
);

  localparam int CNT_BITS = $clog2(FRAME_BITS + 1);

  // configuration
  cfg_t cfg_r;

  // pulse register
  logic                  pls_valid_r;
  logic [WIDTH_BITS-1:0] pls_width_r;

  // frame state
  phase_t                phase_r;
  pclass_t               first_class_r;
  logic [CNT_BITS-1:0]   bit_count_r;
  logic [WORD_BITS-1:0]  shift_word_r;

  phase_t                phase_nxt;
  pclass_t               first_class_nxt;
  logic [CNT_BITS-1:0]   bit_count_nxt;
  logic [WORD_BITS-1:0]  shift_word_nxt;
  logic                  step_emit;
  result_t               step_result;

  // result register
  logic                  out_valid_r;
  result_t               out_res_r;

  logic                  in_fire;
  logic                  advance;

  assign cfg_ready = 1'b1;

  // pulse moves on whenever the result register is free or being emptied
  assign advance  = pls_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = pls_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_min  <= SYNC_MIN_RST;
      cfg_r.sync_max  <= SYNC_MAX_RST;
      cfg_r.long_min  <= LONG_MIN_RST;
      cfg_r.long_max  <= LONG_MAX_RST;
      cfg_r.short_min <= SHORT_MIN_RST;
      cfg_r.short_max <= SHORT_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_MIN:  cfg_r.sync_min  <= cfg_data;
        CFG_SYNC_MAX:  cfg_r.sync_max  <= cfg_data;
        CFG_LONG_MIN:  cfg_r.long_min  <= cfg_data;
        CFG_LONG_MAX:  cfg_r.long_max  <= cfg_data;
        CFG_SHORT_MIN: cfg_r.short_min <= cfg_data;
        CFG_SHORT_MAX: cfg_r.short_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // pulse register: valid is control, width is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pls_valid_r <= 1'b0;
    end else if (in_fire) begin
      pls_valid_r <= 1'b1;
    end else if (advance) begin
      pls_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pls_width_r <= in_pulse_width;
    end
  end

  ookd_step #(
    .FRAME_BITS (FRAME_BITS),
    .CNT_BITS   (CNT_BITS)
  ) u_step (
    .pulse_width     (pls_width_r),
    .cfg             (cfg_r),
    .phase           (phase_r),
    .first_class     (first_class_r),
    .bit_count       (bit_count_r),
    .shift_word      (shift_word_r),
    .phase_nxt       (phase_nxt),
    .first_class_nxt (first_class_nxt),
    .bit_count_nxt   (bit_count_nxt),
    .shift_word_nxt  (shift_word_nxt),
    .emit            (step_emit),
    .result          (step_result)
  );

  // frame state advances with each pulse that leaves the pulse register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      first_class_r <= CL_NONE;
      bit_count_r   <= '0;
      shift_word_r  <= '0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      first_class_r <= first_class_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_word_r  <= shift_word_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_ok      = out_res_r.frame_ok;
  assign out_raw_word      = out_res_r.raw_word;
  assign out_sender_number = out_res_r.sender_number;
  assign out_switch_on     = out_res_r.switch_on;
  assign out_group_flag    = out_res_r.group_flag;
  assign out_protocol_kind = out_res_r.protocol_kind;
  assign out_button_index  = out_res_r.button_index;

  // input stalls only while both stages are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pls_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a full pipeline held at the output");

  // a delivered result is flagged good exactly when its word is nonzero
  a_ok_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.frame_ok == (out_res_r.raw_word != '0)))
    else $error("frame_ok disagrees with raw_word");

  // error results carry all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.frame_ok) |-> (out_res_r == '0))
    else $error("error result with nonzero fields");

  // idle keeps the bit counter and shift word cleared, and the counter stays in the frame
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_count_r == '0 && shift_word_r == '0))
    else $error("frame state not cleared in idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r < CNT_BITS'(FRAME_BITS))
    else $error("bit counter past frame length");

endmodule

/* dv/tb_ook_remote_frame_decoder_core.sv */
// testbench for the ook remote frame decoder: directed table, random frames, checker
module tb_ook_remote_frame_decoder_core import ookd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                    LAST_PULSE   = 2 * FRAME_BITS_DEF;  // sync is pulse 0
  localparam int                    DRAIN_CYCLES = 8;
  localparam int                    CYCLE_LIMIT  = 400000;
  localparam int                    HOLD_CYCLES  = 200;
  localparam logic [WIDTH_BITS-1:0] MAX_W        = 14'd12000;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

  // how the expectation of one transaction is formed
  typedef enum logic [1:0] {
    EXP_MODEL,  // from the predictor
    EXP_QUIET,  // no result
    EXP_ERROR,  // error result, all fields zero
    EXP_GIVEN   // result typed into the table
  } exp_mode_t;

  typedef enum logic {
    ROW_PULSE,
    ROW_FRAME
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [WORD_BITS-1:0] val;   // pulse width or frame word
    exp_mode_t            mode;
    result_t              res;
  } dir_row_t;

  localparam int N_DIRECTED = 27;

  // directed stimulus under the reset windows
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{ROW_PULSE, 32'd0,     EXP_ERROR, '0},  // timeout while idle
    '{ROW_PULSE, 32'd2250,  EXP_ERROR, '0},  // sync bounds are exclusive
    '{ROW_PULSE, 32'd2750,  EXP_ERROR, '0},
    '{ROW_PULSE, 32'd12000, EXP_ERROR, '0},  // widest pulse while idle
    '{ROW_PULSE, 32'd2251,  EXP_QUIET, '0},  // sync opens a frame
    '{ROW_PULSE, 32'd0,     EXP_ERROR, '0},  // timeout as first pulse of a pair
    '{ROW_PULSE, 32'd2749,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd1000,  EXP_ERROR, '0},  // long lower bound, in no window
    '{ROW_PULSE, 32'd2500,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd1499,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd1499,  EXP_ERROR, '0},  // long then long
    '{ROW_PULSE, 32'd2500,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd201,   EXP_QUIET, '0},
    '{ROW_PULSE, 32'd201,   EXP_ERROR, '0},  // short then short
    '{ROW_PULSE, 32'd2500,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd299,   EXP_QUIET, '0},
    '{ROW_PULSE, 32'd0,     EXP_ERROR, '0},  // timeout as second pulse
    '{ROW_PULSE, 32'd2500,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd1001,  EXP_QUIET, '0},
    '{ROW_PULSE, 32'd300,   EXP_ERROR, '0},  // short upper bound is exclusive
    '{ROW_PULSE, 32'd2500,  EXP_MODEL, '0},
    '{ROW_PULSE, 32'd1250,  EXP_MODEL, '0},
    '{ROW_PULSE, 32'd250,   EXP_MODEL, '0},  // one zero bit
    '{ROW_PULSE, 32'd2500,  EXP_MODEL, '0},  // sync width in the middle of a frame
    '{ROW_FRAME, 32'h0000_0000, EXP_ERROR, '0},  // all-zero word is not a good frame
    '{ROW_FRAME, 32'hFFFF_FFFF, EXP_GIVEN,
      '{1'b1, 32'hFFFF_FFFF, 26'h3FF_FFFF, 1'b0, 1'b0, PK_ONES, 2'd3}},
    '{ROW_FRAME, 32'h0000_0001, EXP_GIVEN,
      '{1'b1, 32'h0000_0001, 26'd0, 1'b1, 1'b1, PK_ZEROS, 2'd1}}
  };

  // dut ports, all inputs known from time zero
  logic                    clk               = 1'b0;
  logic                    rst_n             = 1'b0;
  logic                    in_valid          = 1'b0;
  logic                    in_stall;
  logic [WIDTH_BITS-1:0]   in_pulse_width    = '0;
  logic                    out_valid;
  logic                    out_stall         = 1'b0;
  logic                    out_frame_ok;
  logic [WORD_BITS-1:0]    out_raw_word;
  logic [SENDER_BITS-1:0]  out_sender_number;
  logic                    out_switch_on;
  logic                    out_group_flag;
  logic [1:0]              out_protocol_kind;
  logic [1:0]              out_button_index;
  logic                    cfg_valid         = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index         = '0;
  logic [WIDTH_BITS-1:0]   cfg_data          = '0;

  // decoder shadow: windows and frame state
  cfg_t                  win;
  phase_t                frame_phase;
  pclass_t               first_cls;
  logic [5:0]            bit_cnt;
  logic [WORD_BITS-1:0]  shift_reg;

  result_t pending_results [$];  // decoder results still to come, oldest first
  int      mismatch_cnt = 0;
  int      results_seen = 0;
  int      items_sent   = 0;

  ook_remote_frame_decoder_core #(
    .FRAME_BITS (FRAME_BITS_DEF)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pulse_width    (in_pulse_width),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_ok      (out_frame_ok),
    .out_raw_word      (out_raw_word),
    .out_sender_number (out_sender_number),
    .out_switch_on     (out_switch_on),
    .out_group_flag    (out_group_flag),
    .out_protocol_kind (out_protocol_kind),
    .out_button_index  (out_button_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit in_band(input logic [WIDTH_BITS-1:0] w, lo, hi);
    return (w > lo) && (w < hi);
  endfunction

  function automatic result_t split_word(input logic [WORD_BITS-1:0] word);
    result_t r;
    r = '0;
    if (word != '0) begin
      r.frame_ok      = 1'b1;
      r.raw_word      = word;
      r.sender_number = word[WORD_BITS-1:6];
      r.switch_on     = !word[4];
      r.group_flag    = !word[5];
      // protocol code from bits 3..2: both set, both clear, or mixed
      if (word[3:2] == 2'b11) r.protocol_kind = PK_ONES;
      else if (word[3:2] == 2'b00) r.protocol_kind = PK_ZEROS;
      else r.protocol_kind = PK_OTHER;
      r.button_index  = word[1:0];
    end
    return r;
  endfunction

  task automatic clear_frame();
    frame_phase = PH_IDLE;
    first_cls   = CL_NONE;
    bit_cnt     = '0;
    shift_reg   = '0;
  endtask

  // one pulse through the decoder; an abort gives the all-zero error result
  task automatic decode_pulse(input logic [WIDTH_BITS-1:0] w, output bit has_res,
                              output result_t res);
    bit good;
    bit one_bit;
    has_res = 1'b0;
    res     = '0;
    good    = 1'b0;
    one_bit = 1'b0;
    case (frame_phase)
      PH_FIRST: begin
        // long window wins when the two overlap
        if (in_band(w, win.long_min, win.long_max)) begin
          first_cls   = CL_LONG;
          frame_phase = PH_SECOND;
        end else if (in_band(w, win.short_min, win.short_max)) begin
          first_cls   = CL_SHORT;
          frame_phase = PH_SECOND;
        end else begin
          clear_frame();
          has_res = 1'b1;
        end
      end
      PH_SECOND: begin
        if (first_cls == CL_LONG && in_band(w, win.short_min, win.short_max)) begin
          good = 1'b1;
        end else if (first_cls == CL_SHORT && in_band(w, win.long_min, win.long_max)) begin
          good    = 1'b1;
          one_bit = 1'b1;
        end
        if (!good) begin
          clear_frame();
          has_res = 1'b1;
        end else begin
          if (one_bit) shift_reg[WORD_BITS-1-bit_cnt] = 1'b1;
          bit_cnt = bit_cnt + 6'd1;
          if (bit_cnt >= FRAME_BITS_DEF) begin
            res     = split_word(shift_reg);
            has_res = 1'b1;
            clear_frame();
          end else begin
            first_cls   = CL_NONE;
            frame_phase = PH_FIRST;
          end
        end
      end
      default: begin
        clear_frame();
        if (in_band(w, win.sync_min, win.sync_max)) frame_phase = PH_FIRST;
        else has_res = 1'b1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(input string field, input logic [WORD_BITS-1:0] got,
                                 input logic [WORD_BITS-1:0] want);
    $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
    mismatch_cnt++;
  endtask

  // output transaction happens at the next rising edge when valid and not stalled;
  // both are settled by the falling edge
  initial begin : result_monitor
    result_t got;
    result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.frame_ok      = out_frame_ok;
        got.raw_word      = out_raw_word;
        got.sender_number = out_sender_number;
        got.switch_on     = out_switch_on;
        got.group_flag    = out_group_flag;
        got.protocol_kind = out_protocol_kind;
        got.button_index  = out_button_index;
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, raw_word", got.raw_word, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.frame_ok !== want.frame_ok)
            report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
          if (got.raw_word !== want.raw_word)
            report_mismatch("raw_word", got.raw_word, want.raw_word);
          if (got.sender_number !== want.sender_number)
            report_mismatch("sender_number", got.sender_number, want.sender_number);
          if (got.switch_on !== want.switch_on)
            report_mismatch("switch_on", got.switch_on, want.switch_on);
          if (got.group_flag !== want.group_flag)
            report_mismatch("group_flag", got.group_flag, want.group_flag);
          if (got.protocol_kind !== want.protocol_kind)
            report_mismatch("protocol_kind", got.protocol_kind, want.protocol_kind);
          if (got.button_index !== want.button_index)
            report_mismatch("button_index", got.button_index, want.button_index);
        end
      end
    end
  end

  // receiver: random stall, one long hold-off to back the pipe up into in_stall,
  // and a stretch with no stall at all
  initial begin : result_receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 60) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= 150 && results_seen < 350) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [WIDTH_BITS-1:0] pick_in(input logic [WIDTH_BITS-1:0] lo, hi);
    if (hi > lo + 1) return WIDTH_BITS'($urandom_range(hi - 1, lo + 1));
    return WIDTH_BITS'($urandom_range(MAX_W));
  endfunction

  // timeouts, bounds and stray sync widths next to plain random widths
  function automatic logic [WIDTH_BITS-1:0] noise_width();
    case ($urandom_range(9))
      0:       return '0;
      1:       return MAX_W;
      2:       return win.sync_min;
      3:       return pick_in(win.sync_min, win.sync_max);
      default: return WIDTH_BITS'($urandom_range(MAX_W));
    endcase
  endfunction

  // one input transaction; in_stall is sampled at the falling edge so the
  // acceptance decision at the next rising edge is race free
  task automatic send_pulse(input logic [WIDTH_BITS-1:0] w, input exp_mode_t mode,
                            input result_t given);
    bit      stalled;
    bit      has_res;
    result_t res;
    in_valid       <= 1'b1;
    in_pulse_width <= w;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    items_sent++;
    decode_pulse(w, has_res, res);
    case (mode)
      EXP_MODEL: if (has_res) pending_results.push_back(res);
      EXP_ERROR: pending_results.push_back('0);
      EXP_GIVEN: pending_results.push_back(given);
      default:   ;
    endcase
    // sender idle gaps, except for one calm stretch
    if ((items_sent < 700 || items_sent >= 950) && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // sync plus bit pairs; a cut below the last pulse replaces that pulse by noise
  // and ends the frame there
  task automatic send_frame(input logic [WORD_BITS-1:0] word, input int cut,
                            input exp_mode_t last_mode, input result_t last_res);
    logic [WIDTH_BITS-1:0] w;
    bit                    b;
    bit                    first;
    for (int k = 0; k <= cut; k++) begin
      if (k == 0) begin
        w = pick_in(win.sync_min, win.sync_max);
      end else if (k == cut && cut != LAST_PULSE) begin
        w = noise_width();
      end else begin
        b     = word[WORD_BITS - 1 - (k - 1) / 2];
        first = ((k - 1) % 2 == 0);
        // a one is short then long, a zero is long then short
        if (first == b) w = pick_in(win.short_min, win.short_max);
        else w = pick_in(win.long_min, win.long_max);
      end
      if (k == LAST_PULSE) send_pulse(w, last_mode, last_res);
      else send_pulse(w, EXP_MODEL, '0);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [WIDTH_BITS-1:0] data);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
      if (rdy) break;
    end
  endtask

  // writes all windows back to back, plus one write past the list that must be dropped
  task automatic apply_cfg(input cfg_t c);
    cfg_write(CFG_SYNC_MIN,  c.sync_min);
    cfg_write(CFG_SYNC_MAX,  c.sync_max);
    cfg_write(CFG_LONG_MIN,  c.long_min);
    cfg_write(CFG_LONG_MAX,  c.long_max);
    cfg_write(CFG_SHORT_MIN, c.short_min);
    cfg_write(CFG_SHORT_MAX, c.short_max);
    cfg_write(CFG_UNUSED_IDX, WIDTH_BITS'($urandom_range(MAX_W)));
    cfg_valid <= 1'b0;
    win = c;
  endtask

  // quiet the sender, wait for every expected result, then let pulses that give
  // no result leave the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    c = '{SYNC_MIN_RST, SYNC_MAX_RST, LONG_MIN_RST, LONG_MAX_RST,
          SHORT_MIN_RST, SHORT_MAX_RST};
    case (p)
      0: c = '{14'd0, MAX_W, 14'd0, MAX_W, 14'd0, MAX_W};  // all windows wide open
      1: c = '{14'd11998, MAX_W, 14'd5000, 14'd5002, 14'd0, 14'd2};  // one width each
      2: c = '{MAX_W, 14'd0, MAX_W, 14'd0, MAX_W, 14'd0};  // empty windows
      3, 4: begin
        // disjoint windows, short below long below sync
        c.short_min = WIDTH_BITS'($urandom_range(400));
        c.short_max = c.short_min + WIDTH_BITS'($urandom_range(400, 2));
        c.long_min  = c.short_max + WIDTH_BITS'($urandom_range(300));
        c.long_max  = c.long_min + WIDTH_BITS'($urandom_range(2000, 2));
        c.sync_min  = c.long_max + WIDTH_BITS'($urandom_range(500));
        c.sync_max  = c.sync_min + WIDTH_BITS'($urandom_range(3000, 2));
      end
      default: ;
    endcase
    return c;
  endfunction

  // mostly whole frames with random words, some cut short, the rest loose pulses
  task automatic run_random(input int budget);
    int                   start;
    logic [WORD_BITS-1:0] word;
    int                   cut;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(9))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom();
        endcase
        cut = ($urandom_range(99) < 30) ? $urandom_range(LAST_PULSE - 1) : LAST_PULSE;
        send_frame(word, cut, EXP_MODEL, '0);
      end else begin
        send_pulse(noise_width(), EXP_MODEL, '0);
      end
    end
  endtask

  initial begin : stimulus
    int budget [6];
    budget = '{120, 200, 40, 320, 320, 200};
    win = phase_cfg(-1);
    clear_frame();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset windows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_FRAME)
        send_frame(dir_rows[i].val, LAST_PULSE, dir_rows[i].mode, dir_rows[i].res);
      else
        send_pulse(dir_rows[i].val[WIDTH_BITS-1:0], dir_rows[i].mode, dir_rows[i].res);
    end
    settle();

    // random part, one window setting per phase, last phase back at the defaults
    for (int p = 0; p < 6; p++) begin
      apply_cfg(phase_cfg(p));
      run_random(budget[p]);
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
